@@ rtl/svsd_pkg.sv @@
`default_nettype none

package svsd_pkg;

    // Register indexes on the configuration port
    localparam logic [7:0] REG_PHASE_DELAY = 8'd0;
    localparam logic [7:0] REG_STEPS_CHECK = 8'd1;

    // Reset values of the configuration registers
    localparam logic [7:0] PHASE_DELAY_RESET = 8'd5;
    localparam logic [7:0] STEPS_CHECK_RESET = 8'd10;

    // Input item kinds
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_MOVE = 1'b1;

    // Depth of the result queue
    localparam int RES_DEPTH = 2;

    typedef struct packed {
        logic [3:0]         coil_pattern;
        logic               busy_res;
        logic               move_done;
        logic               end_reached;
        logic               fully_open;
        logic               fully_closed;
        logic signed [31:0] valve_position;
    } res_t;

    // Wave drive: one coil per phase, order reversed when closing
    function automatic logic [3:0] phase_coils(input logic [1:0] ph, input logic closing);
        logic [3:0] pat;
        begin
            pat = closing ? (4'b1000 >> ph) : (4'b0001 << ph);
            return pat;
        end
    endfunction

    // A register holding zero behaves as one
    function automatic logic [7:0] at_least_one(input logic [7:0] v);
        logic [7:0] r;
        begin
            r = (v == 8'd0) ? 8'd1 : v;
            return r;
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/stepper_valve_stall_detect.sv @@
`default_nettype none

// Stepper valve driver, wave drive with encoder stall detection.
// Input channel (in_valid/in_stall): one item per transfer, either a time
// tick (kind = 0) or a move command (kind = 1, signed group count in
// move_count), each carrying the current encoder sample.
// Output channel (out_valid/out_stall): exactly one result per input item,
// in order: coil drive, busy, done and end flags, end stops and position.
// Configuration channel (cfg_valid/cfg_ready): index 0 sets the ticks per
// coil phase, index 1 the steps per encoder check; write only while idle.
// cfg_ready is always high.
// A result passes through the input register and then into the two-entry
// result queue.
// Throughput: one item per cycle while in_stall is low; the state
// update is a single pass of counter and compare logic.
// Reset empties the input register and result queue, clears the drive
// state, switches the coils off and loads the register defaults (5 ticks,
// 10 steps). When the receiver stalls, the result queue fills and in_stall
// rises only once the queue and the input register are both holding items.
module stepper_valve_stall_detect
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic                kind,
    input  wire logic signed [15:0]  move_count,
    input  wire logic signed [31:0]  encoder_position,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [3:0]               coil_pattern,
    output logic                     busy_res,
    output logic                     move_done,
    output logic                     end_reached,
    output logic                     fully_open,
    output logic                     fully_closed,
    output logic signed [31:0]       valve_position,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [7:0]          cfg_index,
    input  wire logic [7:0]          cfg_data
);
    import svsd_pkg::*;

    logic [7:0] phase_delay_reg;
    logic [7:0] steps_check_reg;
    logic       item_valid;
    logic       has_space;
    logic       advance;
    logic       load;
    res_t       res;
    res_t       head;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_delay_reg <= PHASE_DELAY_RESET;
            steps_check_reg <= STEPS_CHECK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PHASE_DELAY: phase_delay_reg <= cfg_data;
                REG_STEPS_CHECK: steps_check_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Flow control between input register and result queue
    assign advance  = item_valid & has_space;
    assign in_stall = item_valid & ~has_space;
    assign load     = in_valid & ~in_stall;

    svsd_core u_core
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .load             (load),
        .kind             (kind),
        .move_count       (move_count),
        .encoder_position (encoder_position),
        .advance          (advance),
        .phase_delay      (phase_delay_reg),
        .steps_check      (steps_check_reg),
        .item_valid       (item_valid),
        .res              (res)
    );

    svsd_outq u_outq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (advance),
        .push_data (res),
        .out_stall (out_stall),
        .has_space (has_space),
        .out_valid (out_valid),
        .head      (head)
    );

    assign coil_pattern   = head.coil_pattern;
    assign busy_res       = head.busy_res;
    assign move_done      = head.move_done;
    assign end_reached    = head.end_reached;
    assign fully_open     = head.fully_open;
    assign fully_closed   = head.fully_closed;
    assign valve_position = head.valve_position;

endmodule

`default_nettype wire

@@ rtl/svsd_core.sv @@
`default_nettype none

module svsd_core
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                load,
    input  wire logic                kind,
    input  wire logic signed [15:0]  move_count,
    input  wire logic signed [31:0]  encoder_position,
    input  wire logic                advance,
    input  wire logic [7:0]          phase_delay,
    input  wire logic [7:0]          steps_check,
    output logic                     item_valid,
    output svsd_pkg::res_t           res
);
    import svsd_pkg::*;

    // Input register
    logic               item_valid_reg;
    logic               kind_reg;
    logic [15:0]        cnt_reg;
    logic [31:0]        enc_reg;

    // Drive state
    logic [1:0]         phase_reg,   phase_next;
    logic [7:0]         hold_reg,    hold_next;
    logic [7:0]         step_reg,    step_next;
    logic [15:0]        groups_reg,  groups_next;
    logic               closing_reg, closing_next;
    logic               moving_reg,  moving_next;
    logic [31:0]        start_reg,   start_next;
    logic [31:0]        pos_reg,     pos_next;
    logic               open_reg,    open_next;
    logic               closed_reg,  closed_next;
    logic [3:0]         coil_reg,    coil_next;
    logic               done;
    logic               at_end;

    logic [7:0]         dly;
    logic [7:0]         spc;
    logic [7:0]         hold_inc;
    logic [7:0]         step_inc;
    logic               neg;

    assign dly      = at_least_one(phase_delay);
    assign spc      = at_least_one(steps_check);
    assign hold_inc = hold_reg + 8'd1;
    assign step_inc = step_reg + 8'd1;
    assign neg      = cnt_reg[15];

    // Input register load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= load | (item_valid_reg & ~advance);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= kind;
            cnt_reg  <= move_count;
            enc_reg  <= encoder_position;
        end
    end

    // Next state for the item held in the input register
    always_comb
    begin
        phase_next   = phase_reg;
        hold_next    = hold_reg;
        step_next    = step_reg;
        groups_next  = groups_reg;
        closing_next = closing_reg;
        moving_next  = moving_reg;
        start_next   = start_reg;
        pos_next     = pos_reg;
        open_next    = open_reg;
        closed_next  = closed_reg;
        coil_next    = coil_reg;
        done         = 1'b0;
        at_end       = 1'b0;

        if (kind_reg == KIND_MOVE)
        begin
            if (!moving_reg)
            begin
                if (cnt_reg == 16'd0)
                begin
                    done = 1'b1;
                end
                else if ((open_reg && !neg) || (closed_reg && neg))
                begin
                    done   = 1'b1;
                    at_end = 1'b1;
                end
                else
                begin
                    moving_next  = 1'b1;
                    closing_next = neg;
                    groups_next  = neg ? (16'd0 - cnt_reg) : cnt_reg;
                    phase_next   = 2'd0;
                    hold_next    = 8'd0;
                    step_next    = 8'd0;
                    start_next   = enc_reg;
                    coil_next    = phase_coils(2'd0, neg);
                end
            end
        end
        else if (moving_reg)
        begin
            hold_next = hold_inc;
            if (hold_inc >= dly)
            begin
                hold_next = 8'd0;
                if (phase_reg != 2'd3)
                begin
                    phase_next = phase_reg + 2'd1;
                    coil_next  = phase_coils(phase_reg + 2'd1, closing_reg);
                end
                else
                begin
                    phase_next = 2'd0;
                    step_next  = step_inc;
                    if (step_inc >= spc)
                    begin
                        if (enc_reg == start_reg)
                        begin
                            // stalled against the end stop
                            open_next   = ~closing_reg;
                            closed_next = closing_reg;
                            moving_next = 1'b0;
                            groups_next = 16'd0;
                            done        = 1'b1;
                            at_end      = 1'b1;
                        end
                        else
                        begin
                            if (closing_reg)
                            begin
                                pos_next  = pos_reg - {24'd0, spc};
                                open_next = 1'b0;
                            end
                            else
                            begin
                                pos_next    = pos_reg + {24'd0, spc};
                                closed_next = 1'b0;
                            end
                            groups_next = groups_reg - 16'd1;
                            if (groups_reg == 16'd1)
                            begin
                                moving_next = 1'b0;
                                done        = 1'b1;
                            end
                            else
                            begin
                                hold_next  = 8'd0;
                                step_next  = 8'd0;
                                start_next = enc_reg;
                                coil_next  = phase_coils(2'd0, closing_reg);
                            end
                        end
                    end
                    else
                    begin
                        coil_next = phase_coils(2'd0, closing_reg);
                    end
                end
            end
        end
    end

    // State update on each item passed to the result queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= 2'd0;
            hold_reg    <= 8'd0;
            step_reg    <= 8'd0;
            groups_reg  <= 16'd0;
            closing_reg <= 1'b0;
            moving_reg  <= 1'b0;
            start_reg   <= 32'd0;
            pos_reg     <= 32'd0;
            open_reg    <= 1'b0;
            closed_reg  <= 1'b0;
            coil_reg    <= 4'd0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            hold_reg    <= hold_next;
            step_reg    <= step_next;
            groups_reg  <= groups_next;
            closing_reg <= closing_next;
            moving_reg  <= moving_next;
            start_reg   <= start_next;
            pos_reg     <= pos_next;
            open_reg    <= open_next;
            closed_reg  <= closed_next;
            coil_reg    <= coil_next;
        end
    end

    assign item_valid         = item_valid_reg;
    assign res.coil_pattern   = coil_next;
    assign res.busy_res       = moving_next;
    assign res.move_done      = done;
    assign res.end_reached    = at_end;
    assign res.fully_open     = open_next;
    assign res.fully_closed   = closed_next;
    assign res.valve_position = pos_next;

endmodule

`default_nettype wire

@@ rtl/svsd_outq.sv @@
`default_nettype none

module svsd_outq
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire svsd_pkg::res_t push_data,
    input  wire logic           out_stall,
    output logic                has_space,
    output logic                out_valid,
    output svsd_pkg::res_t      head
);
    import svsd_pkg::*;

    localparam int PTR_W = $clog2(RES_DEPTH);
    localparam int CNT_W = $clog2(RES_DEPTH + 1);

    res_t               mem [RES_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid & ~out_stall;
    assign has_space = (count_reg != CNT_W'(RES_DEPTH)) | pop;
    assign head      = mem[rd_ptr_reg];

    // Result storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(RES_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(RES_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CNT_W'(push) - CNT_W'(pop);
        end
    end

endmodule

`default_nettype wire

@@ rtl/svsd_check.sv @@
`default_nettype none

module svsd_check
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [3:0]  coil_pattern,
    input  wire logic        busy_res,
    input  wire logic        move_done,
    input  wire logic        end_reached,
    input  wire logic        fully_open,
    input  wire logic        fully_closed
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn while stalled");

    // End flag only comes with a finished move
    a_end_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_reached |-> move_done)
        else $error("end_reached without move_done");

    // A finished move leaves the block idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && move_done |-> !busy_res)
        else $error("move_done while still busy");

    // While moving exactly one coil is driven
    a_wave_drive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && busy_res |-> $onehot(coil_pattern))
        else $error("coil pattern not one-hot during a move");

    // Both end stops cannot be flagged together
    a_stops_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(fully_open && fully_closed))
        else $error("both end stops flagged");

endmodule

bind stepper_valve_stall_detect svsd_check u_svsd_check
(
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .coil_pattern (coil_pattern),
    .busy_res     (busy_res),
    .move_done    (move_done),
    .end_reached  (end_reached),
    .fully_open   (fully_open),
    .fully_closed (fully_closed)
);

`default_nettype wire

@@ tb/tb_stepper_valve_stall_detect.sv @@
module tb_stepper_valve_stall_detect;
    timeunit 1ns;
    timeprecision 1ps;

    import svsd_pkg::*;

    localparam int IDLE_LIMIT      = 1000;  // cycles with no transfer at all
    localparam int TAIL_CYCLES     = 8;
    localparam int SEQ_TICK_CAP    = 100;   // longest run of ticks in one sequence
    localparam int HOLD_OFF_CYCLES = 50;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                kind;
    logic signed [15:0]  move_count;
    logic signed [31:0]  encoder_position;
    logic                out_valid;
    logic                out_stall;
    logic [3:0]          coil_pattern;
    logic                busy_res;
    logic                move_done;
    logic                end_reached;
    logic                fully_open;
    logic                fully_closed;
    logic signed [31:0]  valve_position;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [7:0]          cfg_index;
    logic [7:0]          cfg_data;

    // Valve status predictor and the queue of status words it expects
    class valve_status_tracker;
        localparam int REPORT_LINES = 20;

        logic [7:0]  cfg_delay;
        logic [7:0]  cfg_steps;
        logic [1:0]  phase_idx;
        logic [7:0]  hold_cnt;
        logic [7:0]  step_cnt;
        logic [16:0] groups_to_go;
        logic        closing;
        logic        in_motion;
        logic [31:0] grp_ref_enc;
        logic [31:0] pos_acc;
        logic        at_open;
        logic        at_closed;
        logic [3:0]  coils;

        res_t status_q[$];
        int   err_count;
        int   n_items;
        int   n_cmds;
        int   n_results;
        int   n_done;
        int   n_end;

        function new();
            cfg_delay    = PHASE_DELAY_RESET;
            cfg_steps    = STEPS_CHECK_RESET;
            phase_idx    = '0;
            hold_cnt     = '0;
            step_cnt     = '0;
            groups_to_go = '0;
            closing      = 1'b0;
            in_motion    = 1'b0;
            grp_ref_enc  = '0;
            pos_acc      = '0;
            at_open      = 1'b0;
            at_closed    = 1'b0;
            coils        = '0;
            err_count    = 0;
            n_items      = 0;
            n_cmds       = 0;
            n_results    = 0;
            n_done       = 0;
            n_end        = 0;
        endfunction

        function void write_reg(logic [7:0] idx, logic [7:0] val);
            if (idx == REG_PHASE_DELAY)
                cfg_delay = val;
            else if (idx == REG_STEPS_CHECK)
                cfg_steps = val;
        endfunction

        function int pending();
            return status_q.size();
        endfunction

        // one coil at a time, D first when closing
        function logic [3:0] coil_for_phase(logic [1:0] ph, logic dir_close);
            return dir_close ? (4'b1000 >> ph) : (4'b0001 << ph);
        endfunction

        function void begin_group(logic [31:0] enc);
            phase_idx   = '0;
            hold_cnt    = '0;
            step_cnt    = '0;
            grp_ref_enc = enc;
            coils       = coil_for_phase(2'd0, closing);
        endfunction

        // Advance the valve by one accepted item and queue the status it gives
        function void predict_item(logic k, logic [15:0] cnt, logic [31:0] enc);
            logic [7:0] dly;
            logic [7:0] spc;
            logic       done;
            logic       at_end;
            res_t       want;
            dly    = (cfg_delay == 8'd0) ? 8'd1 : cfg_delay;
            spc    = (cfg_steps == 8'd0) ? 8'd1 : cfg_steps;
            done   = 1'b0;
            at_end = 1'b0;
            n_items++;
            if (k == KIND_MOVE)
            begin
                n_cmds++;
                if (!in_motion)
                begin
                    if (cnt == 16'd0)
                        done = 1'b1;
                    else if ((at_open && !cnt[15]) || (at_closed && cnt[15]))
                    begin
                        done   = 1'b1;
                        at_end = 1'b1;
                    end
                    else
                    begin
                        in_motion    = 1'b1;
                        closing      = cnt[15];
                        groups_to_go = cnt[15] ? (17'h10000 - {1'b0, cnt}) : {1'b0, cnt};
                        begin_group(enc);
                    end
                end
            end
            else if (in_motion)
            begin
                hold_cnt = hold_cnt + 8'd1;
                if (hold_cnt >= dly)
                begin
                    hold_cnt = '0;
                    if (phase_idx != 2'd3)
                    begin
                        phase_idx = phase_idx + 2'd1;
                        coils     = coil_for_phase(phase_idx, closing);
                    end
                    else
                    begin
                        phase_idx = '0;
                        step_cnt  = step_cnt + 8'd1;
                        if (step_cnt >= spc)
                        begin
                            if (enc == grp_ref_enc)
                            begin
                                // encoder did not move: end stop in this direction
                                at_closed    = closing;
                                at_open      = !closing;
                                in_motion    = 1'b0;
                                groups_to_go = '0;
                                done         = 1'b1;
                                at_end       = 1'b1;
                            end
                            else
                            begin
                                if (closing)
                                begin
                                    pos_acc = pos_acc - {24'd0, spc};
                                    at_open = 1'b0;
                                end
                                else
                                begin
                                    pos_acc   = pos_acc + {24'd0, spc};
                                    at_closed = 1'b0;
                                end
                                groups_to_go = groups_to_go - 17'd1;
                                if (groups_to_go == 17'd0)
                                begin
                                    in_motion = 1'b0;
                                    done      = 1'b1;
                                end
                                else
                                    begin_group(enc);
                            end
                        end
                        else
                            coils = coil_for_phase(2'd0, closing);
                    end
                end
            end
            if (done)
                n_done++;
            if (at_end)
                n_end++;
            want.coil_pattern   = coils;
            want.busy_res       = in_motion;
            want.move_done      = done;
            want.end_reached    = at_end;
            want.fully_open     = at_open;
            want.fully_closed   = at_closed;
            want.valve_position = pos_acc;
            status_q.push_back(want);
        endfunction

        task report(input string what, input logic [31:0] got, input logic [31:0] want);
            err_count++;
            if (err_count <= REPORT_LINES)
                $display("MISMATCH at %0t, result %0d: %s got %h expected %h",
                         $time, n_results, what, got, want);
        endtask

        task check_result(input res_t got);
            res_t want;
            n_results++;
            if (status_q.size() == 0)
            begin
                report("result with nothing expected", got.valve_position, 32'd0);
                return;
            end
            want = status_q.pop_front();
            if (got.coil_pattern !== want.coil_pattern)
                report("coil_pattern", 32'(got.coil_pattern), 32'(want.coil_pattern));
            if (got.busy_res !== want.busy_res)
                report("busy_res", 32'(got.busy_res), 32'(want.busy_res));
            if (got.move_done !== want.move_done)
                report("move_done", 32'(got.move_done), 32'(want.move_done));
            if (got.end_reached !== want.end_reached)
                report("end_reached", 32'(got.end_reached), 32'(want.end_reached));
            if (got.fully_open !== want.fully_open)
                report("fully_open", 32'(got.fully_open), 32'(want.fully_open));
            if (got.fully_closed !== want.fully_closed)
                report("fully_closed", 32'(got.fully_closed), 32'(want.fully_closed));
            if (got.valve_position !== want.valve_position)
                report("valve_position", got.valve_position, want.valve_position);
        endtask

        task check_drained();
            if (status_q.size() != 0)
                report("status words never delivered", status_q.size(), 32'd0);
        endtask
    endclass

    valve_status_tracker sb;
    res_t                seen;
    logic [31:0]         enc_now;
    bit                  in_gaps_on;
    int                  hold_off_req;
    int                  idle_cycles;
    int                  n_cfg;

    stepper_valve_stall_detect u_dut (.*);

    // 100 MHz clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Output monitor: every transfer is checked against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen.coil_pattern   = coil_pattern;
            seen.busy_res       = busy_res;
            seen.move_done      = move_done;
            seen.end_reached    = end_reached;
            seen.fully_open     = fully_open;
            seen.fully_closed   = fully_closed;
            seen.valve_position = valve_position;
            sb.check_result(seen);
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Watchdog: no transfer for %0d cycles", idle_cycles);
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Result receiver: random stalls, plus a long hold-off on request
    initial
    begin : receiver
        int stall_left;
        int free_left;
        int r;
        int hold_off_seen;
        out_stall     = 1'b0;
        stall_left    = 0;
        free_left     = 0;
        hold_off_seen = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_seen != hold_off_req)
            begin
                hold_off_seen = hold_off_req;
                stall_left    = HOLD_OFF_CYCLES;
                free_left     = 0;
            end
            if (stall_left == 0 && free_left == 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                    free_left = $urandom_range(1, 30);
                else if (r < 90)
                    stall_left = $urandom_range(1, 3);
                else
                    stall_left = $urandom_range(8, 30);
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                free_left--;
            end
        end
    end

    function automatic int pick_in_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    // Ticks needed for one full group at the current register values
    function automatic int group_ticks();
        int d;
        int s;
        d = (sb.cfg_delay == 8'd0) ? 1 : int'(sb.cfg_delay);
        s = (sb.cfg_steps == 8'd0) ? 1 : int'(sb.cfg_steps);
        return 4 * d * s;
    endfunction

    function automatic int capped(input int n);
        return (n > SEQ_TICK_CAP) ? SEQ_TICK_CAP : n;
    endfunction

    function automatic void step_encoder();
        if ($urandom_range(0, 9) == 0)
            enc_now = $urandom;
        else
            enc_now = enc_now + $urandom_range(1, 64);
    endfunction

    // One input transfer, after an optional gap; valid stays up afterwards
    task automatic send_item(input logic k, input logic [15:0] c, input logic [31:0] e);
        int gap;
        gap = in_gaps_on ? pick_in_gap() : 0;
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid         <= 1'b1;
        kind             <= k;
        move_count       <= c;
        encoder_position <= e;
        do
        begin
            @(posedge clk);
        end
        while (in_stall !== 1'b0);
        sb.predict_item(k, c, e);
    endtask

    task automatic stop_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic run_ticks(input int n, input bit hold_enc);
        repeat (n)
        begin
            if (!hold_enc)
                step_encoder();
            send_item(KIND_TICK, 16'($urandom), enc_now);
        end
    endtask

    task automatic cfg_write(input logic [7:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(posedge clk);
        end
        while (cfg_ready !== 1'b1);
        sb.write_reg(idx, val);
        n_cfg++;
    endtask

    // Registers change only once every queued status word has come out
    task automatic set_config(input logic [7:0] dly, input logic [7:0] steps);
        stop_input();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_write(REG_PHASE_DELAY, dly);
        cfg_write(REG_STEPS_CHECK, steps);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random_seq();
        int          sel;
        int          mag;
        int          gl;
        bit          neg;
        bit          hold_enc;
        logic [15:0] cnt;
        gl  = group_ticks();
        sel = $urandom_range(0, 99);
        neg = 1'($urandom_range(0, 1));
        if (sel < 55)
        begin
            // well-formed move: command, then ticks to finish it or stall it
            sel = $urandom_range(0, 9);
            if (sel < 7)
                mag = $urandom_range(1, 3);
            else if (sel < 9)
                mag = $urandom_range(4, 300);
            else
                mag = neg ? 32768 : 32767;
            cnt      = neg ? 16'(-mag) : 16'(mag);
            hold_enc = (mag > 3) || ($urandom_range(0, 3) == 0);
            send_item(KIND_MOVE, cnt, enc_now);
            run_ticks(capped((hold_enc ? gl : mag * gl) + $urandom_range(0, 2)), hold_enc);
        end
        else if (sel < 68)
        begin
            // frozen encoder: a move still running can end at a stop
            run_ticks(capped(2 * gl + 2), 1'b1);
        end
        else if (sel < 85)
        begin
            // noise
            repeat ($urandom_range(1, 8))
            begin
                step_encoder();
                send_item(1'($urandom), 16'($urandom), enc_now);
            end
        end
        else
        begin
            case ($urandom_range(0, 2))
                0: send_item(KIND_MOVE, 16'd0, enc_now);
                1:
                begin
                    // second command lands while the first is running
                    send_item(KIND_MOVE, neg ? 16'hFFFF : 16'd1, enc_now);
                    step_encoder();
                    send_item(KIND_MOVE, 16'($urandom), enc_now);
                    run_ticks(capped(gl + 2), 1'b0);
                end
                default:
                begin
                    // hit an end, knock on it again, then back off
                    send_item(KIND_MOVE, neg ? 16'h8000 : 16'h7FFF, enc_now);
                    run_ticks(capped(gl + 2), 1'b1);
                    send_item(KIND_MOVE, neg ? 16'hFFFF : 16'd1, enc_now);
                    send_item(KIND_MOVE, neg ? 16'd1 : 16'hFFFF, enc_now);
                    run_ticks(capped(gl + 2), 1'b0);
                end
            endcase
        end
    endtask

    task automatic run_phase(input logic [7:0] dly, input logic [7:0] steps, input int budget,
                             input bit gaps, input bit squeeze);
        int start;
        set_config(dly, steps);
        in_gaps_on = gaps;
        if (squeeze)
            hold_off_req++;
        start = sb.n_items;
        while (sb.n_items - start < budget)
            run_random_seq();
    endtask

    initial
    begin : stimulus
        sb               = new();
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        kind             = KIND_TICK;
        move_count       = '0;
        encoder_position = '0;
        cfg_valid        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        enc_now          = '0;
        in_gaps_on       = 1'b1;
        hold_off_req     = 0;
        n_cfg            = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: one-tick phases and one-step groups keep moves short
        set_config(8'd1, 8'd1);
        send_item(KIND_TICK, 16'd0, 32'd0);
        send_item(KIND_MOVE, 16'd0, 32'd0);             // zero command
        send_item(KIND_MOVE, 16'd1, 32'd100);           // one group opening
        send_item(KIND_TICK, 16'd0, 32'd101);
        send_item(KIND_TICK, 16'd0, 32'd102);
        send_item(KIND_TICK, 16'd0, 32'd103);
        send_item(KIND_TICK, 16'd0, 32'd104);           // encoder moved, done
        send_item(KIND_MOVE, 16'd1, 32'd104);
        run_ticks(4, 1'b1);                             // encoder moved, done
        enc_now = 32'h8000_0000;
        send_item(KIND_MOVE, 16'h7FFF, enc_now);        // opening, no end flagged
        send_item(KIND_MOVE, 16'h8000, enc_now);        // full negative count
        enc_now = 32'h7FFF_FFFF;
        run_ticks(4, 1'b1);                             // one group moved
        send_item(KIND_MOVE, 16'd5, 32'd0);             // dropped while busy
        run_ticks(4, 1'b1);                             // stall at open end
        send_item(KIND_MOVE, 16'hFFFF, enc_now);        // closing, away from flagged end

        // Random phases over a spread of register values
        run_phase(8'd1, 8'd1, 60, 1'b0, 1'b1);          // back to back, long hold-off
        run_phase(8'd0, 8'd0, 55, 1'b1, 1'b0);
        run_phase(8'd2, 8'd3, 60, 1'b1, 1'b0);
        run_phase(PHASE_DELAY_RESET, STEPS_CHECK_RESET, 45, 1'b1, 1'b0);
        run_phase(8'd255, 8'd255, 40, 1'b1, 1'b0);
        run_phase(8'd3, 8'd1, 55, 1'b1, 1'b0);          // may change mid-move
        run_phase(8'd1, 8'd2, 60, 1'b0, 1'b0);
        run_phase(8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)), 60, 1'b1, 1'b0);

        // Drain
        stop_input();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        sb.check_drained();

        $display("Covered %0d items (%0d commands) across %0d register writes, values 0 to 255",
                 sb.n_items, sb.n_cmds, n_cfg);
        $display("%0d moves or commands finished, %0d at an end stop; %0d results, %0d mismatches",
                 sb.n_done, sb.n_end, sb.n_results, sb.err_count);
        if (sb.err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
